// ----- rtl/core/ccrn_pkg.sv -----
// Package: shared types, constants and the exp2 root table of the response normalizer.
package ccrn_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MUL_W    = 32;
   localparam int SUM_W    = 36;
   localparam int CNT_W    = 5;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [3:0]  WINDOW_SIZE_RESET   = 4'd5;
   localparam logic [15:0] BIAS_K_RESET        = 16'd512;
   localparam logic [31:0] SCALE_ALPHA_RESET   = 32'd429497;
   localparam logic [15:0] EXPONENT_BETA_RESET = 16'd12288;

   localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE   = 2'd0,
      CSR_BIAS_K        = 2'd1,
      CSR_SCALE_ALPHA   = 2'd2,
      CSR_EXPONENT_BETA = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SQ,
      ST_SQ_ACC,
      ST_PICK,
      ST_AL0,
      ST_AL1,
      ST_AL2,
      ST_DSUM,
      ST_NORM,
      ST_LOG_MUL,
      ST_LOG_USE,
      ST_BETA,
      ST_BETA_USE,
      ST_EXP_MUL,
      ST_EXP_USE,
      ST_SCALE,
      ST_SCALE_USE,
      ST_ROUND,
      ST_EMIT
   } state_type;

   typedef logic [15:0][MUL_W-1:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] b;
      rem = v;
      r   = '0;
      b   = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // entry i holds 2^(2^-(i+1)) in Q2.30, floor sqrt chain
   function automatic root_tab_type root_table();
      root_tab_type t;
      logic [63:0]  r;
      r = isqrt64(64'h1 << 61);
      for (int i = 0; i < 16; i++) begin
         t[i] = r[MUL_W-1:0];
         r    = isqrt64(r << 30);
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TABLE = root_table();

endpackage

// ----- rtl/core/ccrn_if.sv -----
// Interfaces: request and response item channels with valid/ready handshake.
interface ccrn_req_if;
   import ccrn_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_feature;

   modport source (output valid, output sample, output last_feature, input ready);
   modport sink   (input valid, input sample, input last_feature, output ready);
endinterface

interface ccrn_rsp_if;
   import ccrn_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] normalized;
   logic                       last_out;

   modport source (output valid, output normalized, output last_out, input ready);
   modport sink   (input valid, input normalized, input last_out, output ready);
endinterface

// ----- rtl/core/ccrn_mul.sv -----
// Shared unsigned multiplier with registered product.
module ccrn_mul (
   input  logic                           clock,
   input  logic [ccrn_pkg::MUL_W-1:0]     op_a,
   input  logic [ccrn_pkg::MUL_W-1:0]     op_b,
   output logic [2*ccrn_pkg::MUL_W-1:0]   prod
);
   import ccrn_pkg::*;

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/cross_channel_response_normalizer_unit.sv -----
// Top level: cross-channel local response normalizer, one shared multiplier under a sequencer.
//
// Features of one pixel enter on req_chan (sample, last_feature), one item per
// handshake. Each result leaves on rsp_chan (normalized, last_out) as
// sample * (k + alpha * sum of squares)^-beta, saturated to signed Q8.8.
// Results lag the input by the forward window extent; the item carrying
// last_feature flushes all pending results, oldest first, last_out on the final.
// Registers are written through csr_write_enable / csr_index / csr_write_data.
// Every product goes through one 32x32 multiplier, and one result sums the
// squares of up to 15 window entries. A last item yields up to 8 results
// back to back through the sequencer.
// req_chan.ready is high only while the sequencer is idle. A finished result
// sits in an output register, so the next item is taken while it waits;
// when rsp_chan stalls, the sequencer holds at its next result.
// Synchronous reset clears the window, the feature count, the registers to
// their defaults and the output valid flag.
module cross_channel_response_normalizer_unit #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   ccrn_req_if.sink                          req_chan,
   ccrn_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [ccrn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccrn_pkg::CSR_W-1:0]        csr_write_data
);
   import ccrn_pkg::*;

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SZ_CAP = (MAX_WINDOW < 15) ? MAX_WINDOW : 15;
   localparam logic [3:0] SZ_CAP_V = 4'(SZ_CAP);

   // configuration
   logic [3:0]  window_size_ff;
   logic [15:0] bias_k_ff;
   logic [31:0] scale_alpha_ff;
   logic [15:0] exponent_beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= WINDOW_SIZE_RESET;
         bias_k_ff        <= BIAS_K_RESET;
         scale_alpha_ff   <= SCALE_ALPHA_RESET;
         exponent_beta_ff <= EXPONENT_BETA_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_SIZE:   window_size_ff   <= csr_write_data[3:0];
            CSR_BIAS_K:        bias_k_ff        <= csr_write_data[15:0];
            CSR_SCALE_ALPHA:   scale_alpha_ff   <= csr_write_data[31:0];
            CSR_EXPONENT_BETA: exponent_beta_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // window geometry
   logic [3:0] sz0;
   logic [3:0] sz;
   logic [2:0] half;
   logic [2:0] fwd;

   assign sz0  = (window_size_ff == 4'd0) ? 4'd1 : window_size_ff;
   assign sz   = (sz0 > SZ_CAP_V) ? SZ_CAP_V : sz0;
   assign half = sz[3:1];
   assign fwd  = 3'(sz - 4'd1 - {1'b0, half});

   // sequencer registers
   state_type         state_ff, state_in;
   logic [15:0]       win_ff [MAX_WINDOW];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              last_ff, last_in;
   logic [2:0]        p_ff, p_in;
   logic [3:0]        j_ff, j_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [15:0]       samp_ff, samp_in;
   logic [67:0]       acc_ff, acc_in;
   logic [36:0]       d_ff, d_in;
   logic [5:0]        lz_ff, lz_in;
   logic [2:0]        step_ff, step_in;
   logic [30:0]       y_ff, y_in;
   logic [15:0]       fr_ff, fr_in;
   logic [3:0]        rnd_ff, rnd_in;
   logic              lneg_ff, lneg_in;
   logic [9:0]        n_ff, n_in;
   logic [31:0]       x_ff, x_in;
   logic [47:0]       q_ff, q_in;
   logic              big_ff, big_in;
   logic [15:0]       res_in;

   logic              rsp_valid_ff;
   logic [15:0]       rsp_norm_ff;
   logic              rsp_last_ff;

   logic              req_fire;
   logic              out_free;
   logic              load_out;
   logic              win_clear;

   logic [MUL_W-1:0]   op_a, op_b;
   logic [2*MUL_W-1:0] mul_prod;

   ccrn_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (mul_prod)
   );

   // single read port into the window
   logic [3:0]       sel4;
   logic [IDX_W-1:0] rd_idx;
   logic [15:0]      rd_word;
   logic [15:0]      rd_mag;
   logic [15:0]      samp_mag;
   logic [3:0]       hi;

   assign sel4     = (state_ff == ST_PICK) ? {1'b0, p_ff} : j_ff;
   assign rd_idx   = IDX_W'(sel4);
   assign rd_word  = win_ff[rd_idx];
   assign rd_mag   = rd_word[15] ? 16'(~rd_word + 16'd1) : rd_word;
   assign samp_mag = samp_ff[15] ? 16'(~samp_ff + 16'd1) : samp_ff;
   assign hi       = {1'b0, p_ff} + {1'b0, half};

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // datapath helpers
   logic [36:0] d_sum;
   logic [31:0] log_t;
   logic [6:0]  l_hi;
   logic [22:0] l_val;
   logic [22:0] l_mag;
   logic [37:0] beta_p;
   logic [39:0] g_val;
   logic [63:0] exp_rnd;
   logic [10:0] sh_v;
   logic [5:0]  sh_amt;
   logic [47:0] r_val;
   logic        samp_pos;
   logic [36:0] dn;
   logic [5:0]  lzn;

   assign d_sum    = {1'b0, acc_ff[67:32]} + {13'b0, bias_k_ff, 8'b0};
   assign log_t    = mul_prod[61:30];
   assign l_hi     = {1'b0, 6'(6'd36 - lz_ff)} - 7'd16;
   assign l_val    = {l_hi, fr_ff};
   assign l_mag    = l_val[22] ? 23'(~l_val + 23'd1) : l_val;
   assign beta_p   = mul_prod[37:0];
   assign g_val    = lneg_ff ? (40'd8192 + {2'b0, beta_p}) : (40'd8192 - {2'b0, beta_p});
   assign exp_rnd  = mul_prod + (64'h1 << 29);
   assign sh_v     = 11'd30 - {n_ff[9], n_ff};
   assign sh_amt   = 6'(sh_v - 11'd1);
   assign r_val    = 48'(({1'b0, q_ff} + 49'd1) >> 1);
   assign samp_pos = !samp_ff[15];

   always_comb begin
      dn  = d_ff;
      lzn = lz_ff;
      case (step_ff)
         3'd0: if (d_ff[36:5] == '0) begin
            dn = d_ff << 32; lzn = lz_ff + 6'd32;
         end
         3'd1: if (d_ff[36:21] == '0) begin
            dn = d_ff << 16; lzn = lz_ff + 6'd16;
         end
         3'd2: if (d_ff[36:29] == '0) begin
            dn = d_ff << 8; lzn = lz_ff + 6'd8;
         end
         3'd3: if (d_ff[36:33] == '0) begin
            dn = d_ff << 4; lzn = lz_ff + 6'd4;
         end
         3'd4: if (d_ff[36:35] == '0) begin
            dn = d_ff << 2; lzn = lz_ff + 6'd2;
         end
         3'd5: if (!d_ff[36]) begin
            dn = d_ff << 1; lzn = lz_ff + 6'd1;
         end
         default: ;
      endcase
   end

   // next state and datapath control
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      p_in      = p_ff;
      j_in      = j_ff;
      sum_in    = sum_ff;
      samp_in   = samp_ff;
      acc_in    = acc_ff;
      d_in      = d_ff;
      lz_in     = lz_ff;
      step_in   = step_ff;
      y_in      = y_ff;
      fr_in     = fr_ff;
      rnd_in    = rnd_ff;
      lneg_in   = lneg_ff;
      n_in      = n_ff;
      x_in      = x_ff;
      q_in      = q_ff;
      big_in    = big_ff;
      res_in    = '0;
      op_a      = '0;
      op_b      = '0;
      load_out  = 1'b0;
      win_clear = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_in  = req_chan.last_feature;
               count_in = (count_ff == '1) ? count_ff : count_ff + 5'd1;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            j_in   = '0;
            sum_in = '0;
            if (last_ff) begin
               p_in     = ((count_ff - 5'd1) > {2'b0, fwd}) ? fwd : 3'(count_ff - 5'd1);
               state_in = ST_SQ;
            end else if (count_ff > {2'b0, fwd}) begin
               p_in     = fwd;
               state_in = ST_SQ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQ: begin
            op_a     = {16'b0, rd_mag};
            op_b     = {16'b0, rd_mag};
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            sum_in = sum_ff + {4'b0, mul_prod[31:0]};
            if (j_ff == hi) begin
               state_in = ST_PICK;
            end else begin
               j_in     = j_ff + 4'd1;
               state_in = ST_SQ;
            end
         end
         ST_PICK: begin
            samp_in = rd_word;
            if (rd_word == '0) begin
               res_in   = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_AL0;
            end
         end
         ST_AL0: begin
            op_a     = {16'b0, sum_ff[15:0]};
            op_b     = scale_alpha_ff;
            state_in = ST_AL1;
         end
         ST_AL1: begin
            acc_in   = {4'b0, mul_prod};
            op_a     = {12'b0, sum_ff[35:16]};
            op_b     = scale_alpha_ff;
            state_in = ST_AL2;
         end
         ST_AL2: begin
            acc_in   = acc_ff + {mul_prod[51:0], 16'b0};
            state_in = ST_DSUM;
         end
         ST_DSUM: begin
            if (d_sum == '0) begin
               if (exponent_beta_ff == '0) begin
                  res_in = samp_ff;
               end else begin
                  res_in = samp_pos ? SAT_POS : SAT_NEG;
               end
               state_in = ST_EMIT;
            end else begin
               d_in     = d_sum;
               lz_in    = '0;
               step_in  = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            d_in  = dn;
            lz_in = lzn;
            if (step_ff == 3'd5) begin
               y_in     = dn[36:6];
               fr_in    = '0;
               rnd_in   = '0;
               state_in = ST_LOG_MUL;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_LOG_MUL: begin
            op_a     = {1'b0, y_ff};
            op_b     = {1'b0, y_ff};
            state_in = ST_LOG_USE;
         end
         ST_LOG_USE: begin
            fr_in = {fr_ff[14:0], log_t[31]};
            y_in  = log_t[31] ? log_t[31:1] : log_t[30:0];
            if (rnd_ff == 4'd15) begin
               state_in = ST_BETA;
            end else begin
               rnd_in   = rnd_ff + 4'd1;
               state_in = ST_LOG_MUL;
            end
         end
         ST_BETA: begin
            lneg_in  = l_val[22];
            op_a     = {16'b0, exponent_beta_ff};
            op_b     = {11'b0, l_mag[20:0]};
            state_in = ST_BETA_USE;
         end
         ST_BETA_USE: begin
            n_in     = g_val[39:30];
            fr_in    = g_val[29:14];
            x_in     = 32'h4000_0000;
            rnd_in   = '0;
            state_in = ST_EXP_MUL;
         end
         ST_EXP_MUL: begin
            op_a     = x_ff;
            op_b     = ROOT_TABLE[rnd_ff];
            state_in = ST_EXP_USE;
         end
         ST_EXP_USE: begin
            if (fr_ff[15]) begin
               x_in = exp_rnd[61:30];
            end
            fr_in = {fr_ff[14:0], 1'b0};
            if (rnd_ff == 4'd15) begin
               state_in = ST_SCALE;
            end else begin
               rnd_in   = rnd_ff + 4'd1;
               state_in = ST_EXP_MUL;
            end
         end
         ST_SCALE: begin
            op_a     = {16'b0, samp_mag};
            op_b     = x_ff;
            state_in = ST_SCALE_USE;
         end
         ST_SCALE_USE: begin
            big_in = ($signed(n_ff) >= 10'sd30);
            if (sh_v >= 11'd48) begin
               q_in = '0;
            end else begin
               q_in = mul_prod[47:0] >> sh_amt;
            end
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (last_ff && p_ff != '0) begin
                  p_in     = p_ff - 3'd1;
                  j_in     = '0;
                  sum_in   = '0;
                  state_in = ST_SQ;
               end else begin
                  if (last_ff) begin
                     win_clear = 1'b1;
                     count_in  = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result value, held until the output register takes it
   logic [15:0] hold_ff;
   logic [15:0] round_res;

   always_comb begin
      if (big_ff) begin
         round_res = samp_pos ? SAT_POS : SAT_NEG;
      end else if (samp_pos) begin
         round_res = (r_val > 48'd32767) ? SAT_POS : r_val[15:0];
      end else begin
         round_res = (r_val > 48'd32768) ? SAT_NEG : 16'(~r_val[15:0] + 16'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND) begin
         hold_ff <= round_res;
      end else if (state_ff != ST_EMIT) begin
         hold_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      j_ff    <= j_in;
      sum_ff  <= sum_in;
      samp_ff <= samp_in;
      acc_ff  <= acc_in;
      d_ff    <= d_in;
      lz_ff   <= lz_in;
      step_ff <= step_in;
      y_ff    <= y_in;
      fr_ff   <= fr_in;
      rnd_ff  <= rnd_in;
      lneg_ff <= lneg_in;
      n_ff    <= n_in;
      x_ff    <= x_in;
      q_ff    <= q_in;
      big_ff  <= big_in;
   end

   // feature window, newest at entry 0
   always_ff @(posedge clock) begin
      if (reset || win_clear) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else if (req_fire) begin
         win_ff[0] <= req_chan.sample;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_norm_ff <= hold_ff;
         rsp_last_ff <= last_ff && (p_ff == '0);
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.normalized = rsp_norm_ff;
   assign rsp_chan.last_out   = rsp_last_ff;

`ifndef SYNTHESIS
   a_log_norm: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOG_MUL |-> y_ff[30])
      else $error("log2 mantissa left [1,2)");

   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXP_MUL |-> x_ff[31:30] == 2'b01)
      else $error("exp2 product left [1,2)");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   a_pixel_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && last_ff && p_ff == '0)
         |=> (count_ff == '0 && state_ff == ST_IDLE && win_ff[0] == '0))
      else $error("pixel state not cleared after flush");
`endif

endmodule

// ----- dv/testbench.sv -----
// Testbench for the cross-channel response normalizer: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module testbench;
   import ccrn_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] normalized;
      logic                       last_out;
   } norm_result_t;

   class norm_scoreboard;
      logic [3:0]                 window_size;
      logic [15:0]                bias_k;
      logic [31:0]                scale_alpha;
      logic [15:0]                exponent_beta;
      logic signed [SAMPLE_W-1:0] feat_win [16];
      int                         feat_count;
      norm_result_t               pending_results [$];
      int                         errors;

      function new();
         window_size   = WINDOW_SIZE_RESET;
         bias_k        = BIAS_K_RESET;
         scale_alpha   = SCALE_ALPHA_RESET;
         exponent_beta = EXPONENT_BETA_RESET;
         foreach (feat_win[i]) feat_win[i] = '0;
         feat_count = 0;
         errors     = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_WINDOW_SIZE:   window_size   = val[3:0];
            CSR_BIAS_K:        bias_k        = val[15:0];
            CSR_SCALE_ALPHA:   scale_alpha   = val;
            CSR_EXPONENT_BETA: exponent_beta = val[15:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] bit_w;
         rem   = v;
         root  = '0;
         bit_w = 64'h1 << 62;
         while (bit_w > rem) bit_w = bit_w >> 2;
         while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
               rem  = rem - (root + bit_w);
               root = (root >> 1) + bit_w;
            end else begin
               root = root >> 1;
            end
            bit_w = bit_w >> 2;
         end
         return root;
      endfunction

      function logic [63:0] window_sum(int lo, int hi);
         logic [63:0] acc;
         longint      v;
         acc = '0;
         for (int p = lo; p <= hi; p++) begin
            v   = feat_win[p];
            acc = acc + 64'(v * v);
         end
         return acc;
      endfunction

      // sample * (k + alpha*sum)^-beta via fixed-point log2 / exp2
      function logic [15:0] normalize_value(logic signed [SAMPLE_W-1:0] s, logic [63:0] sum);
         logic [63:0] a;
         logic [63:0] d;
         logic [63:0] y;
         logic [63:0] x;
         logic [63:0] root;
         logic [63:0] mag;
         logic [63:0] prod;
         logic [63:0] r;
         logic [15:0] frac_bits;
         logic [15:0] fr;
         longint      log_q16;
         longint      e;
         longint      g16;
         longint      n;
         longint      sh;
         longint      sv;
         int          msb;
         if (s == 0) return '0;
         a = ((sum * scale_alpha[31:16]) + ((sum * scale_alpha[15:0]) >> 16)) >> 16;
         d = a + {40'h0, bias_k, 8'h0};
         if (d == 0) begin
            if (exponent_beta == 0) return s;
            return (s > 0) ? SAT_POS : SAT_NEG;
         end
         msb = 0;
         for (int i = 0; i < 64; i++) if (d[i]) msb = i;
         y = (msb >= 30) ? (d >> (msb - 30)) : (d << (30 - msb));
         frac_bits = '0;
         for (int i = 0; i < 16; i++) begin
            y         = (y * y) >> 30;
            frac_bits = {frac_bits[14:0], 1'b0};
            if (y >= (64'd2 << 30)) begin
               frac_bits[0] = 1'b1;
               y            = y >> 1;
            end
         end
         log_q16 = (longint'(msb) - 16) * 65536 + $signed({48'h0, frac_bits});
         e   = $signed({48'h0, exponent_beta}) * log_q16;
         g16 = (64'sd8192 - e) >>> 14;
         n   = g16 >>> 16;
         fr  = g16[15:0];
         x    = 64'h1 << 30;
         root = int_sqrt(64'h1 << 61);
         for (int b = 15; b >= 0; b--) begin
            if (fr[b]) x = (x * root + (64'h1 << 29)) >> 30;
            root = int_sqrt(root << 30);
         end
         sv   = s;
         mag  = (sv < 0) ? -sv : sv;
         prod = mag * x;
         sh   = 30 - n;
         if (sh <= 0) begin
            if (-sh >= 18) r = 64'h1 << 20;
            else r = prod << (-sh);
         end else if (sh >= 63) begin
            r = '0;
         end else begin
            r = (prod + (64'h1 << (sh - 1))) >> sh;
         end
         if (s > 0) return (r > 32767) ? SAT_POS : r[15:0];
         if (r > 32768) return SAT_NEG;
         r = 64'h0 - r;
         return r[15:0];
      endfunction

      function void note_feature(logic signed [SAMPLE_W-1:0] s, logic lst);
         int           sz;
         int           h;
         int           f;
         int           first;
         int           lo;
         norm_result_t res;
         sz = (window_size == 0) ? 1 : int'(window_size);
         h  = sz / 2;
         f  = sz - 1 - h;
         for (int i = 15; i > 0; i--) feat_win[i] = feat_win[i-1];
         feat_win[0] = s;
         if (feat_count < 31) feat_count++;
         if (!lst) begin
            if (feat_count > f) begin
               res.normalized = normalize_value(feat_win[f], window_sum(0, sz - 1));
               res.last_out   = 1'b0;
               pending_results.push_back(res);
            end
            return;
         end
         // flush the trailing features, oldest first
         first = (feat_count - 1 < f) ? feat_count - 1 : f;
         for (int q = first; q >= 0; q--) begin
            lo = (q - f < 0) ? 0 : q - f;
            res.normalized = normalize_value(feat_win[q], window_sum(lo, q + h));
            res.last_out   = (q == 0);
            pending_results.push_back(res);
         end
         foreach (feat_win[i]) feat_win[i] = '0;
         feat_count = 0;
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] v, logic lst);
         norm_result_t want;
         if (pending_results.size() == 0) begin
            $error("unexpected item: normalized %0d, last_out %0b", v, lst);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (v !== want.normalized) begin
            $error("normalized: expected %0d, actual %0d", want.normalized, v);
            errors++;
         end
         if (lst !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out, lst);
            errors++;
         end
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;
   bit                   no_idle;
   int                   random_items;

   norm_scoreboard sb = new();

   ccrn_req_if req_chan();
   ccrn_rsp_if rsp_chan();

   cross_channel_response_normalizer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [15:0] pick_sample();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = SAT_NEG;
         1: v = SAT_POS;
         2: v = '0;
         3, 4: begin
            v = $urandom_range(1023);
            v = v - 16'd512;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin : rsp_sink
      int hold;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         hold = no_idle ? 1 : $urandom_range(8, 1);
         rsp_chan.ready <= 1'b1;
         repeat (hold) @(negedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.normalized, rsp_chan.last_out);
   end

   task automatic send_feature(input logic [15:0] s, input logic lst);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sample       <= s;
      req_chan.last_feature <= lst;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_feature(s, lst);
      @(negedge clock);
   endtask

   task automatic send_random_pixel(input int len);
      for (int i = 0; i < len; i++) begin
         send_feature(pick_sample(), i == len - 1);
         random_items++;
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic configure(input logic [3:0] ws, input logic [15:0] k,
                            input logic [31:0] alpha, input logic [15:0] beta);
      write_reg(CSR_WINDOW_SIZE, {28'h0, ws});
      write_reg(CSR_BIAS_K, {16'h0, k});
      write_reg(CSR_SCALE_ALPHA, alpha);
      write_reg(CSR_EXPONENT_BETA, {16'h0, beta});
   endtask

   initial begin : stimulus
      logic [3:0]  ws;
      logic [15:0] k;
      logic [31:0] alpha;
      logic [15:0] beta;
      int          len;
      int          phase_end;
      reset                 = 1'b1;
      no_idle               = 1'b0;
      random_items          = 0;
      req_chan.valid        = 1'b0;
      req_chan.sample       = '0;
      req_chan.last_feature = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_WINDOW_SIZE;
      csr_write_data        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: extremes and zero samples
      send_feature(SAT_POS, 1'b0);
      send_feature(SAT_NEG, 1'b0);
      send_feature(16'h0000, 1'b0);
      send_feature(16'h0001, 1'b0);
      send_feature(16'hFFFF, 1'b0);
      send_feature(16'h0100, 1'b1);
      wait_drained();

      // widest window, pixels shorter than the forward extent
      write_reg(CSR_WINDOW_SIZE, 32'd15);
      send_feature(SAT_NEG, 1'b1);
      send_feature(16'd100, 1'b0);
      send_feature(-16'sd200, 1'b0);
      send_feature(16'd300, 1'b1);
      wait_drained();

      // window size zero acts as one
      write_reg(CSR_WINDOW_SIZE, 32'd0);
      send_feature(SAT_POS, 1'b0);
      send_feature(16'h4000, 1'b1);
      wait_drained();

      // zero denominator, beta zero then nonzero
      configure(4'd0, 16'd0, 32'd0, 16'd0);
      send_feature(16'h1234, 1'b0);
      send_feature(-16'sd5, 1'b0);
      send_feature(16'h0000, 1'b1);
      wait_drained();
      write_reg(CSR_EXPONENT_BETA, 32'd65535);
      send_feature(16'h1234, 1'b0);
      send_feature(-16'sd5, 1'b0);
      send_feature(16'h0000, 1'b1);
      wait_drained();

      // window change in the middle of a pixel
      configure(4'd5, 16'd65535, 32'hFFFF_FFFF, 16'd16384);
      send_feature(16'h0300, 1'b0);
      send_feature(-16'sd1024, 1'b0);
      send_feature(16'h7000, 1'b0);
      wait_drained();
      write_reg(CSR_WINDOW_SIZE, 32'd3);
      send_feature(16'h0080, 1'b0);
      send_feature(SAT_NEG, 1'b1);
      wait_drained();

      while (random_items < 460) begin
         case ($urandom_range(4))
            0: ws = 4'd0;
            1: ws = 4'd1;
            2: ws = 4'd15;
            default: ws = $urandom_range(15);
         endcase
         case ($urandom_range(4))
            0: k = 16'd0;
            1: k = 16'd65535;
            2, 3: k = $urandom_range(1024, 128);
            default: k = $urandom;
         endcase
         case ($urandom_range(4))
            0: alpha = 32'd0;
            1: alpha = 32'hFFFF_FFFF;
            2, 3: alpha = $urandom_range(1 << 24);
            default: alpha = $urandom;
         endcase
         case ($urandom_range(4))
            0: beta = 16'd0;
            1: beta = 16'd65535;
            2, 3: beta = $urandom_range(16384, 4096);
            default: beta = $urandom;
         endcase
         configure(ws, k, alpha, beta);
         no_idle   = ($urandom_range(3) == 0);
         phase_end = random_items + $urandom_range(70, 30);
         while (random_items < phase_end) begin
            case ($urandom_range(24))
               0, 1:    len = $urandom_range(40, 32);
               2, 3, 4: len = $urandom_range(20, 13);
               default: len = $urandom_range(12, 1);
            endcase
            send_random_pixel(len);
         end
         wait_drained();
         no_idle = 1'b0;
      end

      wait_drained();
      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/ccrn_pkg.sv
rtl/core/ccrn_if.sv
rtl/core/ccrn_mul.sv
rtl/core/cross_channel_response_normalizer_unit.sv
dv/testbench.sv
